### rtl/wpe_pkg.sv
package wpe_pkg;

    // Default sizes of the line store and the sample word.
    localparam int unsigned MAX_WIDTH_DEF   = 1024;
    localparam int unsigned MAX_KERNEL_DEF  = 8;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // Fixed limits of the register ranges.
    localparam int unsigned ROW_LIMIT   = 1024;
    localparam int unsigned SLICE_LIMIT = 256;

    // Configuration port and result field widths.
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 11;
    localparam int unsigned OUT_COL_W   = 10;
    localparam int unsigned OUT_ROW_W   = 10;
    localparam int unsigned OUT_SLICE_W = 8;

    // Depth of the job queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH  = 3'd0,
        REG_IN_HEIGHT = 3'd1,
        REG_IN_DEPTH  = 3'd2,
        REG_KERNEL    = 3'd3,
        REG_STRIDE    = 3'd4,
        REG_POOL_MODE = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_MAX = 2'd0,
        MODE_MIN = 2'd1,
        MODE_AVG = 2'd2
    } t_pool_mode;

    // Effective (clamped) configuration seen by front and back.
    typedef struct packed {
        logic [10:0] w;
        logic [10:0] h;
        logic [8:0]  d;
        logic [3:0]  k;
        logic [3:0]  s;
        logic [1:0]  mode;
    } t_cfg;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_DRAIN,
        B_DIVLD,
        B_DIV,
        B_OUT
    } t_back_state;

endpackage

### rtl/window_pooling_engine.sv
// Flow: the front registers an accepted sample, resolves its stride position with a
// serial divider and pushes it to the queue; the back pops it and writes the line store.
// A window-closing sample then scans kernel*kernel line store reads and a drain step,
// and average mode adds a serial divide of the sum by the window area.
// The front takes no new sample until it has pushed the last one into the queue.
// Reset is synchronous and active low; the line store is not cleared.
module window_pooling_engine #(
    parameter int unsigned MAX_WIDTH   = wpe_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_KERNEL  = wpe_pkg::MAX_KERNEL_DEF,
    parameter int unsigned SAMPLE_BITS = wpe_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wpe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wpe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [SAMPLE_BITS-1:0]      o_pooled_value,
    output logic [wpe_pkg::OUT_COL_W-1:0]      o_out_col,
    output logic [wpe_pkg::OUT_ROW_W-1:0]      o_out_row,
    output logic [wpe_pkg::OUT_SLICE_W-1:0]    o_out_slice,
    output logic                               o_last_of_volume
);
    import wpe_pkg::*;

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned LW = $clog2(MAX_KERNEL);

    // One accepted sample as it travels from the front to the back.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [CW-1:0]                 col;
        logic [LW-1:0]                 line;
        logic                          emit;
        logic [OUT_COL_W-1:0]          ox;
        logic [OUT_ROW_W-1:0]          oy;
        logic [OUT_SLICE_W-1:0]        oz;
        logic                          last;
    } t_job;

    logic [10:0] r_in_width, r_in_height;
    logic [8:0]  r_in_depth;
    logic [3:0]  r_kernel, r_stride;
    logic [1:0]  r_mode;
    t_cfg        cfg;

    t_job f_job, q_job;
    logic f_push, q_full, q_empty, b_pop;

    // Register writes take effect at once; the index selects the register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width  <= 11'd1;
            r_in_height <= 11'd1;
            r_in_depth  <= 9'd1;
            r_kernel    <= 4'd2;
            r_stride    <= 4'd2;
            r_mode      <= MODE_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IN_WIDTH:  r_in_width  <= i_cfg_data;
                REG_IN_HEIGHT: r_in_height <= i_cfg_data;
                REG_IN_DEPTH:  r_in_depth  <= i_cfg_data[8:0];
                REG_KERNEL:    r_kernel    <= i_cfg_data[3:0];
                REG_STRIDE:    r_stride    <= i_cfg_data[3:0];
                REG_POOL_MODE: r_mode      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Zero sizes act as one and oversize values are held to the store and range limits.
    always_comb begin
        cfg.w = (r_in_width == '0) ? 11'd1 : r_in_width;
        if (int'(r_in_width) > int'(MAX_WIDTH)) cfg.w = 11'(MAX_WIDTH);
        cfg.h = (r_in_height == '0) ? 11'd1 : r_in_height;
        if (int'(r_in_height) > int'(ROW_LIMIT)) cfg.h = 11'(ROW_LIMIT);
        cfg.d = (r_in_depth == '0) ? 9'd1 : r_in_depth;
        if (int'(r_in_depth) > int'(SLICE_LIMIT)) cfg.d = 9'(SLICE_LIMIT);
        cfg.k = (r_kernel == '0) ? 4'd1 : r_kernel;
        if (int'(r_kernel) > int'(MAX_KERNEL)) cfg.k = 4'(MAX_KERNEL);
        cfg.s    = (r_stride == '0) ? 4'd1 : r_stride;
        cfg.mode = r_mode;
    end

    // The front locates each sample and decides whether it closes a window.
    wpe_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS),
        .t_job       (t_job)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .o_full     (full),
        .i_sample   (i_sample),
        .o_job      (f_job),
        .o_job_push (f_push),
        .i_job_full (q_full)
    );

    // A short queue lets the front keep taking samples during a window scan.
    wpe_queue #(
        .t_job (t_job)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (b_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    // The back owns the line store, scans windows and holds the result slot.
    wpe_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS),
        .t_job       (t_job)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_job            (q_job),
        .i_job_empty      (q_empty),
        .o_job_pop        (b_pop),
        .o_pooled_value   (o_pooled_value),
        .o_out_col        (o_out_col),
        .o_out_row        (o_out_row),
        .o_out_slice      (o_out_slice),
        .o_last_of_volume (o_last_of_volume),
        .o_empty          (empty),
        .i_pop            (pop)
    );

endmodule

### rtl/wpe_front.sv
module wpe_front #(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned MAX_KERNEL  = 8,
    parameter int unsigned SAMPLE_BITS = 16,
    parameter type         t_job       = logic
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wpe_pkg::t_cfg                 i_cfg,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output t_job                          o_job,
    output logic                          o_job_push,
    input  logic                          i_job_full
);
    import wpe_pkg::*;

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned LW  = $clog2(MAX_KERNEL);
    localparam int unsigned PW  = (CW > 10) ? CW : 10;
    localparam int unsigned CNW = $clog2(PW + 1);

    t_front_state r_state, n_state;

    logic [CW-1:0]  r_col, n_col;
    logic [9:0]     r_row, n_row;
    logic [7:0]     r_slice, n_slice;
    logic [LW-1:0]  r_line, n_line;

    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [CW-1:0]  r_x;
    logic [LW-1:0]  r_ln;
    logic [7:0]     r_z;
    logic           r_okx, r_oky, r_last;
    logic [PW-1:0]  r_dx, r_dy, n_dx, n_dy;
    logic [3:0]     r_rx, r_ry, n_rx, n_ry;
    logic [CNW-1:0] r_cnt;

    logic [CW-1:0]  x;
    logic [9:0]     y;
    logic [7:0]     z;
    logic [LW-1:0]  ln;
    logic [4:0]     tx, ty;
    logic           accept;

    assign accept = i_push && (r_state == F_IDLE);
    assign o_full = (r_state != F_IDLE);

    // Positions left beyond the extent by a register write restart at zero.
    always_comb begin
        x  = (int'(r_col) >= int'(i_cfg.w)) ? '0 : r_col;
        y  = (int'(r_row) >= int'(i_cfg.h)) ? '0 : r_row;
        z  = (int'(r_slice) >= int'(i_cfg.d)) ? '0 : r_slice;
        ln = (int'(r_row) >= int'(i_cfg.h)) ? '0 : r_line;
    end

    always_comb begin
        n_col   = x;
        n_row   = y;
        n_slice = z;
        n_line  = ln;
        if (int'(x) + 1 >= int'(i_cfg.w)) begin
            n_col = '0;
            if (int'(y) + 1 >= int'(i_cfg.h)) begin
                n_row   = '0;
                n_line  = '0;
                n_slice = (int'(z) + 1 >= int'(i_cfg.d)) ? '0 : z + 8'd1;
            end else begin
                n_row  = y + 10'd1;
                n_line = (int'(ln) + 1 >= int'(MAX_KERNEL)) ? '0 : ln + LW'(1);
            end
        end else begin
            n_col = x + CW'(1);
        end
    end

    // One quotient bit per cycle for column and row offsets over the stride.
    always_comb begin
        tx = {r_rx, r_dx[PW-1]};
        ty = {r_ry, r_dy[PW-1]};
        if (tx >= {1'b0, i_cfg.s}) begin
            n_rx = 4'(tx - {1'b0, i_cfg.s});
            n_dx = {r_dx[PW-2:0], 1'b1};
        end else begin
            n_rx = tx[3:0];
            n_dx = {r_dx[PW-2:0], 1'b0};
        end
        if (ty >= {1'b0, i_cfg.s}) begin
            n_ry = 4'(ty - {1'b0, i_cfg.s});
            n_dy = {r_dy[PW-2:0], 1'b1};
        end else begin
            n_ry = ty[3:0];
            n_dy = {r_dy[PW-2:0], 1'b0};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (accept) n_state = F_DIV;
            F_DIV:  if (int'(r_cnt) == int'(PW) - 1) n_state = F_PUSH;
            F_PUSH: if (!i_job_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    assign o_job_push   = (r_state == F_PUSH) && !i_job_full;
    assign o_job.sample = r_sample;
    assign o_job.col    = r_x;
    assign o_job.line   = r_ln;
    assign o_job.emit   = r_okx && r_oky && (r_rx == 4'd0) && (r_ry == 4'd0);
    assign o_job.ox     = r_dx[9:0];
    assign o_job.oy     = r_dy[9:0];
    assign o_job.oz     = r_z;
    assign o_job.last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_col   <= '0;
            r_row   <= '0;
            r_slice <= '0;
            r_line  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_col   <= n_col;
                r_row   <= n_row;
                r_slice <= n_slice;
                r_line  <= n_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
            r_x      <= x;
            r_ln     <= ln;
            r_z      <= z;
            r_okx    <= (int'(x) + 1 >= int'(i_cfg.k));
            r_oky    <= (int'(y) + 1 >= int'(i_cfg.k));
            r_dx     <= PW'(int'(x) + 1 - int'(i_cfg.k));
            r_dy     <= PW'(int'(y) + 1 - int'(i_cfg.k));
            r_rx     <= '0;
            r_ry     <= '0;
            r_cnt    <= '0;
            // The window is the last one of the volume when one more stride
            // would run past both slice edges and the slice is the last one.
            r_last   <= (int'(x) + 1 + int'(i_cfg.s) > int'(i_cfg.w)) &&
                        (int'(y) + 1 + int'(i_cfg.s) > int'(i_cfg.h)) &&
                        (int'(z) + 1 == int'(i_cfg.d));
        end else if (r_state == F_DIV) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_rx  <= n_rx;
            r_ry  <= n_ry;
            r_cnt <= r_cnt + CNW'(1);
        end
    end

endmodule

### rtl/wpe_queue.sv
module wpe_queue #(
    parameter type t_job = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);
    import wpe_pkg::*;

    localparam int unsigned DEPTH = QUEUE_DEPTH;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW    = $clog2(DEPTH + 1);

    t_job          r_buf [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (int'(r_cnt) == int'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (int'(r_wp) == int'(DEPTH) - 1) ? '0 : r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= (int'(r_rp) == int'(DEPTH) - 1) ? '0 : r_rp + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

endmodule

### rtl/wpe_back.sv
module wpe_back #(
    parameter int unsigned MAX_WIDTH   = 1024,
    parameter int unsigned MAX_KERNEL  = 8,
    parameter int unsigned SAMPLE_BITS = 16,
    parameter type         t_job       = logic
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  wpe_pkg::t_cfg                          i_cfg,
    input  t_job                                   i_job,
    input  logic                                   i_job_empty,
    output logic                                   o_job_pop,
    output logic signed [SAMPLE_BITS-1:0]          o_pooled_value,
    output logic [wpe_pkg::OUT_COL_W-1:0]          o_out_col,
    output logic [wpe_pkg::OUT_ROW_W-1:0]          o_out_row,
    output logic [wpe_pkg::OUT_SLICE_W-1:0]        o_out_slice,
    output logic                                   o_last_of_volume,
    output logic                                   o_empty,
    input  logic                                   i_pop
);
    import wpe_pkg::*;

    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned LW   = $clog2(MAX_KERNEL);
    localparam int unsigned SUMW = SAMPLE_BITS + 2 * LW;
    localparam int unsigned DNW  = $clog2(SUMW + 1);

    t_back_state r_state, n_state;

    logic signed [SAMPLE_BITS-1:0] r_mem [MAX_KERNEL][MAX_WIDTH];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic                          r_rd_valid;

    t_job           r_job;
    logic [LW-1:0]  r_rline, start_line;
    logic [CW-1:0]  r_col0;
    logic [3:0]     r_ri, r_ci;
    logic           r_first;

    logic signed [SAMPLE_BITS-1:0] r_max, r_min;
    logic signed [SUMW-1:0]        r_sum;

    logic [SUMW-1:0] r_dvd, n_dvd;
    logic [8:0]      r_rem, n_rem;
    logic [9:0]      rem_try;
    logic [7:0]      kk;
    logic            r_neg;
    logic [DNW-1:0]  r_dcnt;

    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] result;
    logic [SUMW-1:0]               quot_signed;
    logic                          scan_end, load_out;

    assign o_job_pop = (r_state == B_IDLE) && !i_job_empty;
    assign scan_end  = (r_ri == i_cfg.k - 4'd1) && (r_ci == i_cfg.k - 4'd1);
    assign load_out  = (r_state == B_OUT) && (!r_out_valid || i_pop);
    assign kk        = i_cfg.k * i_cfg.k;

    always_comb begin
        if (int'(i_job.line) + 1 >= int'(i_cfg.k)) begin
            start_line = LW'(int'(i_job.line) + 1 - int'(i_cfg.k));
        end else begin
            start_line = LW'(int'(i_job.line) + 1 - int'(i_cfg.k) + int'(MAX_KERNEL));
        end
    end

    // Restoring divide of the sum magnitude by the window area.
    always_comb begin
        rem_try = {r_rem, r_dvd[SUMW-1]};
        if (rem_try >= {2'b00, kk}) begin
            n_rem = 9'(rem_try - {2'b00, kk});
            n_dvd = {r_dvd[SUMW-2:0], 1'b1};
        end else begin
            n_rem = rem_try[8:0];
            n_dvd = {r_dvd[SUMW-2:0], 1'b0};
        end
    end

    always_comb begin
        quot_signed = r_neg ? SUMW'(-r_dvd) : r_dvd;
        if (i_cfg.mode == MODE_MIN) begin
            result = r_min;
        end else if (i_cfg.mode == MODE_AVG) begin
            result = quot_signed[SAMPLE_BITS-1:0];
        end else begin
            result = r_max;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (!i_job_empty && i_job.emit) n_state = B_SCAN;
            B_SCAN:  if (scan_end) n_state = B_DRAIN;
            B_DRAIN: n_state = (i_cfg.mode == MODE_AVG) ? B_DIVLD : B_OUT;
            B_DIVLD: n_state = B_DIV;
            B_DIV:   if (int'(r_dcnt) == int'(SUMW) - 1) n_state = B_OUT;
            B_OUT:   if (load_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == B_SCAN);
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line store: one write per sample, one registered read per scan step.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_mem[i_job.line][i_job.col] <= i_job.sample;
        end
        r_rd_data <= r_mem[r_rline][r_col0 + CW'(r_ci)];
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job   <= i_job;
            r_rline <= start_line;
            r_col0  <= CW'(int'(i_job.col) + 1 - int'(i_cfg.k));
            r_ri    <= '0;
            r_ci    <= '0;
            r_first <= 1'b1;
        end else if (r_state == B_SCAN) begin
            if (r_ci == i_cfg.k - 4'd1) begin
                r_ci    <= '0;
                r_ri    <= r_ri + 4'd1;
                r_rline <= (int'(r_rline) + 1 >= int'(MAX_KERNEL)) ? '0 : r_rline + LW'(1);
            end else begin
                r_ci <= r_ci + 4'd1;
            end
        end
        if (r_rd_valid) begin
            r_first <= 1'b0;
            if (r_first || r_rd_data > r_max) r_max <= r_rd_data;
            if (r_first || r_rd_data < r_min) r_min <= r_rd_data;
            r_sum <= (r_first ? '0 : r_sum) + SUMW'(r_rd_data);
        end
        if (r_state == B_DIVLD) begin
            r_neg  <= r_sum[SUMW-1];
            r_dvd  <= r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (r_state == B_DIV) begin
            r_dvd  <= n_dvd;
            r_rem  <= n_rem;
            r_dcnt <= r_dcnt + DNW'(1);
        end
        if (load_out) begin
            o_pooled_value   <= result;
            o_out_col        <= r_job.ox;
            o_out_row        <= r_job.oy;
            o_out_slice      <= r_job.oz;
            o_last_of_volume <= r_job.last;
        end
    end

    assign o_empty = !r_out_valid;

endmodule

### rtl/wpe_checker.sv
module wpe_checker #(
    parameter int unsigned SAMPLE_BITS = wpe_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic signed [SAMPLE_BITS-1:0] o_pooled_value,
    input logic                          o_last_of_volume
);

    // After reset nothing waits and the input side is open.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue flags wrong after reset");

    // The front shows full while it works on a sample after a transfer.
    a_busy_after_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full)
        else $error("front took no time for a sample");

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pooled_value) &&
                              $stable(o_last_of_volume)))
        else $error("waiting result changed or vanished");

endmodule

bind window_pooling_engine wpe_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wpe_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .push             (push),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .o_pooled_value   (o_pooled_value),
    .o_last_of_volume (o_last_of_volume)
);
